FILE: hw/rtl/karsc_pkg.sv
package karsc_pkg;

    // Alphabet size and symbol codes.
    localparam int unsigned SYM_COUNT = 29;
    localparam logic [4:0] SYM_LAST_CODE = 5'd28;
    localparam logic [4:0] SYM_COMMA = 5'd26;
    localparam logic [4:0] SYM_PERIOD = 5'd27;
    localparam logic [4:0] SYM_SPACE = 5'd28;
    localparam logic [4:0] NO_SYMBOL = 5'd31;

    // ASCII codes used by the symbol mapping.
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] ASCII_PERIOD = 8'h2E;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // Request kinds on the op field.
    localparam logic OP_KEY = 1'b0;
    localparam logic OP_MESSAGE = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_WAIT_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic key_accept;
        logic msg_accept;
        logic fill_step;
        logic out_load;
    } karsc_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic sym_valid;
        logic key_ready;
        logic fill_last;
        logic out_free;
    } karsc_stat_t;

    // Map a raw byte to its symbol code, or NO_SYMBOL outside the alphabet.
    function automatic logic [4:0] symbol_of(input logic [7:0] byte_in);
        logic [7:0] c;
        logic [4:0] s;
        c = byte_in;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            c = c - ASCII_CASE_OFFSET;
        end
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            s = 5'(c - ASCII_UPPER_A);
        end
        else if (c == ASCII_COMMA) begin
            s = SYM_COMMA;
        end
        else if (c == ASCII_PERIOD) begin
            s = SYM_PERIOD;
        end
        else if (c == ASCII_SPACE) begin
            s = SYM_SPACE;
        end
        else begin
            s = NO_SYMBOL;
        end
        return s;
    endfunction

    // Map a symbol code back to its ASCII character.
    function automatic logic [7:0] symbol_ascii(input logic [4:0] sym);
        logic [7:0] a;
        if (sym < SYM_COMMA) begin
            a = ASCII_UPPER_A + {3'b000, sym};
        end
        else if (sym == SYM_COMMA) begin
            a = ASCII_COMMA;
        end
        else if (sym == SYM_PERIOD) begin
            a = ASCII_PERIOD;
        end
        else begin
            a = ASCII_SPACE;
        end
        return a;
    endfunction

endpackage

FILE: hw/rtl/karsc_ctrl.sv
module karsc_ctrl
    import karsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        op,
    input  logic        key_last,
    input  karsc_stat_t stat,
    output logic        in_stall,
    output karsc_cmd_t  cmd,
    output state_t      state
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                in_stall = 1'b0;
                if (in_valid) begin
                    if (op == OP_KEY) begin
                        cmd.key_accept = 1'b1;
                        if (key_last) begin
                            state_next = ST_FILL;
                        end
                    end
                    else if (stat.key_ready && stat.sym_valid) begin
                        cmd.msg_accept = 1'b1;
                        state_next = ST_WAIT_OUT;
                    end
                end
            end
            ST_FILL: begin
                // Append one unused symbol per cycle until the table is full.
                cmd.fill_step = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: hw/rtl/karsc_dp.sv
module karsc_dp
    import karsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        out_stall,
    input  karsc_cmd_t  cmd,
    output karsc_stat_t stat,
    output logic        out_valid,
    output logic [7:0]  cipher_char
);

    logic [4:0]  key_mem [SYM_COUNT];
    logic [28:0] used_reg;
    logic [28:0] used_next;
    logic [4:0]  len_reg;
    logic [4:0]  len_next;
    logic [4:0]  index_reg;
    logic [4:0]  index_next;
    logic        ready_reg;
    logic        ready_next;
    logic [4:0]  fill_cnt_reg;
    logic [4:0]  fill_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [4:0]  rd_data_reg;
    logic [7:0]  out_char_reg;

    logic [4:0]  sym;
    logic [28:0] used_eff;
    logic [31:0] used_pad;
    logic [4:0]  len_eff;
    logic [4:0]  app_sym;
    logic        app_en;
    logic [5:0]  idx_sum;
    logic [4:0]  idx_new;
    logic        fill_last;

    assign sym = symbol_of(char_in);
    assign fill_last = (fill_cnt_reg == SYM_LAST_CODE);

    // A key byte after a completed key starts over from an empty table.
    assign used_eff = ready_reg ? '0 : used_reg;
    assign len_eff = ready_reg ? '0 : len_reg;
    assign used_pad = {3'b000, used_eff};

    // Append logic shared by key bytes and the completion sweep.
    assign app_sym = cmd.fill_step ? fill_cnt_reg : sym;
    assign app_en = (cmd.key_accept || cmd.fill_step) && (app_sym <= SYM_LAST_CODE)
                    && (len_eff <= SYM_LAST_CODE) && !used_pad[app_sym];

    // Running index update modulo the alphabet size.
    assign idx_sum = {1'b0, index_reg} + {1'b0, sym} + 6'd1;
    assign idx_new = (idx_sum > {1'b0, SYM_LAST_CODE}) ? 5'(idx_sum - 6'(SYM_COUNT))
                                                        : idx_sum[4:0];

    // Next values of the key state.
    always_comb begin
        used_next = used_reg;
        len_next = len_reg;
        index_next = index_reg;
        ready_next = ready_reg;
        fill_cnt_next = fill_cnt_reg;
        if (cmd.key_accept || cmd.fill_step) begin
            used_next = used_eff | (app_en ? (29'd1 << app_sym) : '0);
            len_next = len_eff + {4'b0000, app_en};
        end
        if (cmd.key_accept) begin
            ready_next = 1'b0;
            index_next = '0;
            fill_cnt_next = '0;
        end
        if (cmd.fill_step) begin
            if (fill_last) begin
                ready_next = 1'b1;
                index_next = '0;
                fill_cnt_next = '0;
            end
            else begin
                fill_cnt_next = fill_cnt_reg + 5'd1;
            end
        end
        if (cmd.msg_accept) begin
            index_next = idx_new;
        end
    end

    // Output register handshake.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            used_reg <= '0;
            len_reg <= '0;
            index_reg <= '0;
            ready_reg <= 1'b0;
            fill_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            used_reg <= used_next;
            len_reg <= len_next;
            index_reg <= index_next;
            ready_reg <= ready_next;
            fill_cnt_reg <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Key table memory with registered read.
    always_ff @(posedge clk) begin
        if (app_en) begin
            key_mem[len_eff] <= app_sym;
        end
        if (cmd.msg_accept) begin
            rd_data_reg <= key_mem[idx_new];
        end
    end

    // Output payload register.
    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_char_reg <= symbol_ascii(rd_data_reg);
        end
    end

    assign stat.sym_valid = (sym <= SYM_LAST_CODE);
    assign stat.key_ready = ready_reg;
    assign stat.fill_last = fill_last;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign cipher_char = out_char_reg;

endmodule

FILE: hw/rtl/keyed_alphabet_running_sum_cipher.sv
// Message request: the result passes the key read register, then the output register;
// input is stalled until it is loaded. Key request: the one marked last adds a sweep
// that appends the unused symbols one per cycle, during which input is stalled.
// Message requests without a completed key, or outside the alphabet, give no result.
// Reset (rst_n, asynchronous, active low) empties the key and clears the output.
module keyed_alphabet_running_sum_cipher
    import karsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] char_in,
    input  logic       key_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cipher_char
);

    karsc_cmd_t  cmd;
    karsc_stat_t stat;
    state_t      state;

    // Sequencer for key completion and result hand-off.
    karsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .key_last (key_last),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd),
        .state    (state)
    );

    // Key table, running index and output register.
    karsc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .cipher_char (cipher_char)
    );

`ifndef SYNTH
    // A new result only appears after the controller loads it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result appeared without a load");

    // The completion sweep never runs while accepting requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_step |-> (in_stall && !stat.key_ready))
        else $error("sweep overlaps request acceptance or a ready key");

    // Loading never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

    // An accepted message leads to the result hand-off state in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.msg_accept |=> (state == ST_WAIT_OUT))
        else $error("message accepted without result hand-off");
`endif

endmodule
